@@ hdl/sts_pkg.sv @@
package sts_pkg;

    localparam int DEPTH       = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int COUNT_W     = $clog2(DEPTH + 1);
    localparam int INDEX_W     = 10;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_REPORT
    } state_t;

endpackage

@@ hdl/sorted_table_binary_search_top.sv @@
// Channel   Handshake             Payload
// in        in_valid / in_stall   kind[1:0], item_value[31:0] signed
// out       out_valid / out_stall found, match_index[9:0]
//
// Append, clear and unused kinds are handled in idle; they give no result.
// A search goes through probe and compare for each probe, after the accept in idle
// and before the report state, and on a miss through one more probe that finds the
// range empty: at most 11 probes and a miss at the full table of 1024 entries. The
// table memory read is registered, and the compare state uses the read data.
// Reset clears the entry count and control state; the table memory is not cleared.
// A result waits in the output register while out_stall is high; the next item
// is taken meanwhile, and a search that ends holds in report until the slot frees.
module sorted_table_binary_search_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             kind,
    input  logic signed [sts_pkg::VALUE_WIDTH-1:0] item_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   found,
    output logic [sts_pkg::INDEX_W-1:0]            match_index
);

    logic signed [sts_pkg::VALUE_WIDTH-1:0] table_mem [sts_pkg::DEPTH];

    sts_pkg::state_t                        state_reg, state_next;
    logic [sts_pkg::COUNT_W-1:0]            count_reg, count_next;
    logic [sts_pkg::COUNT_W-1:0]            lo_reg, lo_next;
    logic [sts_pkg::COUNT_W-1:0]            end_reg, end_next;
    logic [sts_pkg::ADDR_W-1:0]             mid_reg, mid_next;
    logic signed [sts_pkg::VALUE_WIDTH-1:0] key_reg, key_next;
    logic                                   hit_reg, hit_next;
    logic [sts_pkg::ADDR_W-1:0]             hit_idx_reg, hit_idx_next;
    logic                                   out_valid_reg, out_valid_next;
    logic                                   found_reg, found_next;
    logic [sts_pkg::INDEX_W-1:0]            match_index_reg, match_index_next;
    logic signed [sts_pkg::VALUE_WIDTH-1:0] rdata_reg;

    logic                                   wr_en;
    logic                                   rd_en;
    logic [sts_pkg::COUNT_W:0]              mid_sum;

    assign in_stall    = (state_reg != sts_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_index = match_index_reg;

    // floor((lo + hi) / 2) with hi = end - 1; end > lo whenever it is used
    assign mid_sum = {1'b0, lo_reg} + {1'b0, end_reg} - {{sts_pkg::COUNT_W{1'b0}}, 1'b1};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[count_reg[sts_pkg::ADDR_W-1:0]] <= item_value;
        end
        if (rd_en)
        begin
            rdata_reg <= table_mem[mid_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sts_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg          <= lo_next;
        end_reg         <= end_next;
        mid_reg         <= mid_next;
        key_reg         <= key_next;
        hit_reg         <= hit_next;
        hit_idx_reg     <= hit_idx_next;
        found_reg       <= found_next;
        match_index_reg <= match_index_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        lo_next          = lo_reg;
        end_next         = end_reg;
        mid_next         = mid_reg;
        key_next         = key_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        found_next       = found_reg;
        match_index_next = match_index_reg;
        out_valid_next   = out_valid_reg && out_stall;
        wr_en            = 1'b0;
        rd_en            = 1'b0;

        unique case (state_reg)
            sts_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind)
                        sts_pkg::KIND_APPEND:
                        begin
                            // drop the value once the table is full
                            if (count_reg < sts_pkg::COUNT_W'(sts_pkg::DEPTH))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        sts_pkg::KIND_SEARCH:
                        begin
                            lo_next    = '0;
                            end_next   = count_reg;
                            key_next   = item_value;
                            state_next = sts_pkg::ST_PROBE;
                        end
                        sts_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            sts_pkg::ST_PROBE:
            begin
                if (lo_reg < end_reg)
                begin
                    mid_next   = mid_sum[sts_pkg::ADDR_W:1];
                    rd_en      = 1'b1;
                    state_next = sts_pkg::ST_COMPARE;
                end
                else
                begin
                    hit_next     = 1'b0;
                    hit_idx_next = '0;
                    state_next   = sts_pkg::ST_REPORT;
                end
            end
            sts_pkg::ST_COMPARE:
            begin
                priority if (rdata_reg == key_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = mid_reg;
                    state_next   = sts_pkg::ST_REPORT;
                end
                else if (key_reg < rdata_reg)
                begin
                    end_next   = {1'b0, mid_reg};
                    state_next = sts_pkg::ST_PROBE;
                end
                else
                begin
                    lo_next    = {1'b0, mid_reg} + 1'b1;
                    state_next = sts_pkg::ST_PROBE;
                end
            end
            sts_pkg::ST_REPORT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    found_next       = hit_reg;
                    match_index_next = sts_pkg::INDEX_W'(hit_idx_reg);
                    state_next       = sts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/sts_checker.sv @@
module sts_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_stall,
    input logic [1:0]                             kind,
    input logic signed [sts_pkg::VALUE_WIDTH-1:0] item_value,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic                                   found,
    input logic [sts_pkg::INDEX_W-1:0]            match_index
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(match_index))
        else $error("stalled result changed or dropped");

    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_index == '0)
        else $error("miss reported with nonzero index");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == sts_pkg::KIND_SEARCH |=> in_stall)
        else $error("search item not held busy");

    a_single_cycle_ops: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind != sts_pkg::KIND_SEARCH |=> !in_stall)
        else $error("append or clear item did not finish in one cycle");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(kind) && $stable(item_value))
        else $error("stalled input item changed or dropped");

endmodule

bind sorted_table_binary_search_top sts_checker u_sts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .match_index (match_index)
);
